### rtl/barycentric_color_interpolator_macros.svh
// ----------------------------------------------------------------------------
// barycentric color interpolator assertion macros
// shared concurrent check forms, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_COLOR_INTERPOLATOR_MACROS_SVH
`define BARYCENTRIC_COLOR_INTERPOLATOR_MACROS_SVH

// condition holds at every edge out of reset
`define BCI_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/bci_pkg.sv
// ----------------------------------------------------------------------------
// bci_pkg
// widths, register indexes and payload types of the color interpolator
// ----------------------------------------------------------------------------
package bci_pkg;

  localparam int COORD_BITS = 12;
  localparam int PX_W       = 11;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int POS_W      = 2 * COORD_BITS;
  localparam int CFG_W      = (POS_W > COLOR_W) ? POS_W : COLOR_W;
  localparam int IDX_W      = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_A_POS   = 3'd0;
  localparam logic [IDX_W-1:0] REG_B_POS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_C_POS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_A_COLOR = 3'd3;
  localparam logic [IDX_W-1:0] REG_B_COLOR = 3'd4;
  localparam logic [IDX_W-1:0] REG_C_COLOR = 3'd5;

  localparam logic [COLOR_W-1:0] A_COLOR_RST = 24'hFF0000;
  localparam logic [COLOR_W-1:0] B_COLOR_RST = 24'h00FF00;
  localparam logic [COLOR_W-1:0] C_COLOR_RST = 24'h0000FF;

  // datapath widths
  localparam int DIFF_W  = ((COORD_BITS > PX_W + 1) ? COORD_BITS : PX_W + 1) + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int N_W     = SUM_W + 2;
  localparam int CPROD_W = N_W + CH_W + 1;
  localparam int NUM_W   = CPROD_W + 2;
  localparam int DEN_W   = SUM_W;
  localparam int REM_W   = DEN_W + CH_W;

  // pipeline depth: front stages, range check, one stage per quotient bit, output
  localparam int TOP_STAGES = 6;
  localparam int LATENCY    = TOP_STAGES + CH_W + 2;

  typedef struct packed {
    logic [PX_W-1:0] pixel_x;
    logic [PX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            degenerate;
  } result_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } ctl_t;

endpackage

### rtl/bci_clamp_div.sv
// ----------------------------------------------------------------------------
// bci_clamp_div
// pipelined clamped divide of three channel numerators by a positive divisor
// ----------------------------------------------------------------------------
`include "barycentric_color_interpolator_macros.svh"

module bci_clamp_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bci_pkg::ctl_t                         in_ctl,
  input  logic signed [bci_pkg::NUM_W-1:0]      num [bci_pkg::NUM_CH],
  input  logic        [bci_pkg::DEN_W-1:0]      den,
  output logic                                  result_valid,
  output bci_pkg::result_t                      result
);

  localparam int CH_W   = bci_pkg::CH_W;
  localparam int NUM_CH = bci_pkg::NUM_CH;
  localparam int NUM_W  = bci_pkg::NUM_W;
  localparam int DEN_W  = bci_pkg::DEN_W;
  localparam int REM_W  = bci_pkg::REM_W;

  // stage 0 is the range check, stage s+1 holds quotient bits after step s
  bci_pkg::ctl_t     st_ctl  [CH_W+1];
  logic [DEN_W-1:0]  st_den  [CH_W+1];
  logic [REM_W-1:0]  st_rem  [CH_W+1][NUM_CH];
  logic [CH_W-1:0]   st_q    [CH_W+1][NUM_CH];
  logic              st_zero [CH_W+1][NUM_CH];
  logic              st_sat  [CH_W+1][NUM_CH];
  logic [CH_W-1:0]   color   [NUM_CH];

  // range check: non-positive goes to zero, at least 256 times the divisor saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      st_ctl[0] <= '0;
    end else begin
      st_ctl[0] <= in_ctl;
    end
    st_den[0] <= den;
    for (int k = 0; k < NUM_CH; k++) begin
      st_zero[0][k] <= (num[k] <= 0);
      st_sat[0][k]  <= (num[k] >= signed'(NUM_W'({den, {CH_W{1'b0}}})));
      st_rem[0][k]  <= num[k][REM_W-1:0];
      st_q[0][k]    <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < CH_W; s++) begin : g_step
    logic [REM_W-1:0] shifted_den;
    assign shifted_den = REM_W'(st_den[s]) << (CH_W - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[s+1] <= '0;
      end else begin
        st_ctl[s+1] <= st_ctl[s];
      end
      st_den[s+1] <= st_den[s];
    end

    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
      logic [REM_W:0] trial;
      logic           fits;
      assign trial = {1'b0, st_rem[s][k]} - {1'b0, shifted_den};
      assign fits  = !trial[REM_W];

      always_ff @(posedge clk) begin
        st_rem[s+1][k]  <= fits ? trial[REM_W-1:0] : st_rem[s][k];
        st_q[s+1][k]    <= {st_q[s][k][CH_W-2:0], fits};
        st_zero[s+1][k] <= st_zero[s][k];
        st_sat[s+1][k]  <= st_sat[s][k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      priority if (st_ctl[CH_W].degenerate || st_zero[CH_W][k]) begin
        color[k] = '0;
      end else if (st_sat[CH_W][k]) begin
        color[k] = '1;
      end else begin
        color[k] = st_q[CH_W][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= st_ctl[CH_W].valid;
    end
    result <= '{red: color[0], green: color[1], blue: color[2],
                degenerate: st_ctl[CH_W].degenerate};
  end

  `BCI_ASSERT_IMPLY(den_nonzero_chk, clk, rst, in_ctl.valid && !in_ctl.degenerate, den != '0, "divisor zero on a non-degenerate item")

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chk
    `BCI_ASSERT_IMPLY(rem_bound_chk, clk, rst, st_ctl[CH_W].valid && !st_ctl[CH_W].degenerate && !st_zero[CH_W][k] && !st_sat[CH_W][k], st_rem[CH_W][k] < REM_W'(st_den[CH_W]), "remainder not below divisor")
  end

endmodule

### rtl/barycentric_color_interpolator.sv
// ----------------------------------------------------------------------------
// barycentric_color_interpolator
// per-pixel color interpolation over one configured triangle
// ----------------------------------------------------------------------------
// usage:
//   configuration: write vertex positions and colors through cfg_valid /
//   cfg_ready with cfg_index selecting the register (0..2 positions, 3..5
//   colors); indexes above 5 are dropped. write only while no item is in flight.
//   input: an item (pixel) is taken at an edge where start is high and busy is
//   low. busy is low except during reset, so one pixel can enter every cycle.
//   output: each result sits on result for one cycle with result_valid high.
//   the receiver cannot stall the block, so no backpressure exists.
// pipeline: 6 front stages (edge terms, 13x13 products, sums, sign fix, color
//   products, channel sums), one range check stage, eight restoring divide
//   stages (one quotient bit each), one output register.
// throughput: one pixel per cycle outside reset, set by the fully pipelined divider.
// reset: synchronous, clears every valid bit and loads the default vertex
//   registers (all positions zero, colors red, green, blue).
// a zero triangle area yields black with the degenerate flag set.
// ----------------------------------------------------------------------------
`include "barycentric_color_interpolator_macros.svh"

module barycentric_color_interpolator (
  input  logic                            clk,
  input  logic                            rst,
  // pixel input
  input  logic                            start,
  output logic                            busy,
  input  bci_pkg::pixel_t                 pixel,
  // result output
  output logic                            result_valid,
  output bci_pkg::result_t                result,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bci_pkg::IDX_W-1:0]       cfg_index,
  input  logic [bci_pkg::CFG_W-1:0]       cfg_data
);

  localparam int COORD_BITS = bci_pkg::COORD_BITS;
  localparam int POS_W      = bci_pkg::POS_W;
  localparam int COLOR_W    = bci_pkg::COLOR_W;
  localparam int CH_W       = bci_pkg::CH_W;
  localparam int NUM_CH     = bci_pkg::NUM_CH;
  localparam int DIFF_W     = bci_pkg::DIFF_W;
  localparam int PROD_W     = bci_pkg::PROD_W;
  localparam int SUM_W      = bci_pkg::SUM_W;
  localparam int N_W        = bci_pkg::N_W;
  localparam int CPROD_W    = bci_pkg::CPROD_W;
  localparam int NUM_W      = bci_pkg::NUM_W;
  localparam int DEN_W      = bci_pkg::DEN_W;

  // configuration registers
  logic [POS_W-1:0]   pos_a;
  logic [POS_W-1:0]   pos_b;
  logic [POS_W-1:0]   pos_c;
  logic [COLOR_W-1:0] color_a;
  logic [COLOR_W-1:0] color_b;
  logic [COLOR_W-1:0] color_c;
  logic [COLOR_W-1:0] colors [NUM_CH];

  // unpacked vertex coordinates
  logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
  logic signed [DIFF_W-1:0]     px, py;
  logic                         accept;

  // stage 1: edge terms and pixel offsets from vertex c
  logic                     v1;
  logic signed [DIFF_W-1:0] s1_a1, s1_b1, s1_a2, s1_b2, s1_f1, s1_dx, s1_dy;

  // stage 2: edge products
  logic                     v2;
  logic signed [PROD_W-1:0] s2_d0, s2_d1, s2_n1a, s2_n1b, s2_n2a, s2_n2b;

  // stage 3: denominator and two numerators
  logic                    v3;
  logic signed [SUM_W-1:0] s3_d, s3_n1, s3_n2;

  // stage 4: third numerator, sign made positive on the divisor
  logic                    v4;
  logic signed [N_W-1:0]   n3_c;
  logic                    d_neg;
  logic signed [N_W-1:0]   s4_n [NUM_CH];
  logic [DEN_W-1:0]        s4_den;
  logic                    s4_degen;

  // stage 5: weight times vertex channel
  logic                      v5;
  logic signed [CPROD_W-1:0] s5_prod [NUM_CH][NUM_CH];
  logic [DEN_W-1:0]          s5_den;
  logic                      s5_degen;

  // stage 6: channel numerators
  logic                    v6;
  logic signed [NUM_W-1:0] s6_num [NUM_CH];
  logic [DEN_W-1:0]        s6_den;
  logic                    s6_degen;
  bci_pkg::ctl_t           s6_ctl;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a   <= '0;
      pos_b   <= '0;
      pos_c   <= '0;
      color_a <= bci_pkg::A_COLOR_RST;
      color_b <= bci_pkg::B_COLOR_RST;
      color_c <= bci_pkg::C_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bci_pkg::REG_A_POS:   pos_a   <= cfg_data[POS_W-1:0];
        bci_pkg::REG_B_POS:   pos_b   <= cfg_data[POS_W-1:0];
        bci_pkg::REG_C_POS:   pos_c   <= cfg_data[POS_W-1:0];
        bci_pkg::REG_A_COLOR: color_a <= cfg_data[COLOR_W-1:0];
        bci_pkg::REG_B_COLOR: color_b <= cfg_data[COLOR_W-1:0];
        bci_pkg::REG_C_COLOR: color_c <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign colors[0] = color_a;
  assign colors[1] = color_b;
  assign colors[2] = color_c;

  // x in the low half, y in the high half, both two's complement
  assign x1 = pos_a[COORD_BITS-1:0];
  assign y1 = pos_a[POS_W-1:COORD_BITS];
  assign x2 = pos_b[COORD_BITS-1:0];
  assign y2 = pos_b[POS_W-1:COORD_BITS];
  assign x3 = pos_c[COORD_BITS-1:0];
  assign y3 = pos_c[POS_W-1:COORD_BITS];
  assign px = signed'(DIFF_W'(pixel.pixel_x));
  assign py = signed'(DIFF_W'(pixel.pixel_y));

  // valid chain of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    s1_a1 <= DIFF_W'(y2) - DIFF_W'(y3);
    s1_b1 <= DIFF_W'(x3) - DIFF_W'(x2);
    s1_a2 <= DIFF_W'(y3) - DIFF_W'(y1);
    s1_b2 <= DIFF_W'(x1) - DIFF_W'(x3);
    s1_f1 <= DIFF_W'(y1) - DIFF_W'(y3);
    s1_dx <= px - DIFF_W'(x3);
    s1_dy <= py - DIFF_W'(y3);
  end

  // stage 2: six independent multiplies
  always_ff @(posedge clk) begin
    s2_d0  <= PROD_W'(s1_a1) * PROD_W'(s1_b2);
    s2_d1  <= PROD_W'(s1_b1) * PROD_W'(s1_f1);
    s2_n1a <= PROD_W'(s1_a1) * PROD_W'(s1_dx);
    s2_n1b <= PROD_W'(s1_b1) * PROD_W'(s1_dy);
    s2_n2a <= PROD_W'(s1_a2) * PROD_W'(s1_dx);
    s2_n2b <= PROD_W'(s1_b2) * PROD_W'(s1_dy);
  end

  // stage 3: edge function sums
  always_ff @(posedge clk) begin
    s3_d  <= SUM_W'(s2_d0) + SUM_W'(s2_d1);
    s3_n1 <= SUM_W'(s2_n1a) + SUM_W'(s2_n1b);
    s3_n2 <= SUM_W'(s2_n2a) + SUM_W'(s2_n2b);
  end

  // stage 4: n3 = d - n1 - n2, then flip all signs when d is negative
  assign n3_c  = N_W'(s3_d) - N_W'(s3_n1) - N_W'(s3_n2);
  assign d_neg = s3_d[SUM_W-1];

  always_ff @(posedge clk) begin
    s4_n[0]  <= d_neg ? -N_W'(s3_n1) : N_W'(s3_n1);
    s4_n[1]  <= d_neg ? -N_W'(s3_n2) : N_W'(s3_n2);
    s4_n[2]  <= d_neg ? -n3_c : n3_c;
    s4_den   <= d_neg ? DEN_W'(-s3_d) : DEN_W'(s3_d);
    s4_degen <= (s3_d == '0);
  end

  // stage 5: lane k is the channel (red, green, blue), j the vertex
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      for (int j = 0; j < NUM_CH; j++) begin
        s5_prod[k][j] <= CPROD_W'(s4_n[j]) *
                         CPROD_W'(signed'({1'b0, colors[j][(NUM_CH-1-k)*CH_W +: CH_W]}));
      end
    end
    s5_den   <= s4_den;
    s5_degen <= s4_degen;
  end

  // stage 6: channel numerators
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      s6_num[k] <= NUM_W'(s5_prod[k][0]) + NUM_W'(s5_prod[k][1]) + NUM_W'(s5_prod[k][2]);
    end
    s6_den   <= s5_den;
    s6_degen <= s5_degen;
  end

  assign s6_ctl = '{valid: v6, degenerate: s6_degen};

  // clamp, divide and output register
  bci_clamp_div u_div (
    .clk          (clk),
    .rst          (rst),
    .in_ctl       (s6_ctl),
    .num          (s6_num),
    .den          (s6_den),
    .result_valid (result_valid),
    .result       (result)
  );

  // every result strobe traces back to a pixel taken the pipeline depth earlier
  `BCI_ASSERT_IMPLY(latency_chk, clk, rst, result_valid, $past(accept, bci_pkg::LATENCY), "result strobe does not match accepted item")
  // out of reset both input channels are always open
  `BCI_ASSERT_ALWAYS(ready_chk, clk, rst, !busy && cfg_ready, "block not ready out of reset")
  // a degenerate triangle always shades black
  `BCI_ASSERT_IMPLY(degen_black_chk, clk, rst, result_valid && result.degenerate, result.red == '0 && result.green == '0 && result.blue == '0, "degenerate result is not black")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// barycentric color interpolator testbench
// configures triangles through the register channel, streams pixels in random
// bursts and compares every shaded result against an in-bench integer model
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W      = bci_pkg::IDX_W;
  localparam int CFG_W      = bci_pkg::CFG_W;
  localparam int POS_W      = bci_pkg::POS_W;
  localparam int COLOR_W    = bci_pkg::COLOR_W;
  localparam int COORD_BITS = bci_pkg::COORD_BITS;
  localparam int PX_W       = bci_pkg::PX_W;

  // register indexes the block has no register behind; writes must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // cycles with no handshake of any kind before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 96;

  logic clk;
  logic rst = 1'b1;

  logic                start = 1'b0;
  logic                busy;
  bci_pkg::pixel_t     pixel = '0;
  logic                result_valid;
  bci_pkg::result_t    result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  // shadow copy of the triangle registers, tracked from accepted writes
  logic [POS_W-1:0]    tri_pos [3];
  logic [COLOR_W-1:0]  tri_color [3];

  bci_pkg::pixel_t     pixel_backlog [$];
  bci_pkg::result_t    expected_shades [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  barycentric_color_interpolator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // color prediction
  // edge functions in 64-bit integers; with the sign of d folded into the
  // numerator the quotient is exact, then clamped to 0..255
  // ---------------------------------------------------------------------------
  function automatic bci_pkg::result_t shade_pixel(bci_pkg::pixel_t p);
    bci_pkg::result_t r;
    longint      vx [3];
    longint      vy [3];
    longint      px, py, d, n1, n2, n3, num, den, q;
    longint      c1, c2, c3;
    logic [7:0]  ch [3];
    int          sh;
    r = '0;
    for (int v = 0; v < 3; v++) begin
      vx[v] = $signed(tri_pos[v][COORD_BITS-1:0]);
      vy[v] = $signed(tri_pos[v][2*COORD_BITS-1:COORD_BITS]);
    end
    px = p.pixel_x;
    py = p.pixel_y;
    d = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
    // zero area: black, flagged
    if (d == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    n1 = (vy[1] - vy[2]) * (px - vx[2]) + (vx[2] - vx[1]) * (py - vy[2]);
    n2 = (vy[2] - vy[0]) * (px - vx[2]) + (vx[0] - vx[2]) * (py - vy[2]);
    n3 = d - n1 - n2;
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      c1 = tri_color[0][sh +: 8];
      c2 = tri_color[1][sh +: 8];
      c3 = tri_color[2][sh +: 8];
      num = n1 * c1 + n2 * c2 + n3 * c3;
      den = d;
      // clockwise winding: flip both so the divide sees a positive d
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) begin
        q = 0;
      end else begin
        q = num / den;
        if (q > 255) q = 255;
      end
      ch[k] = q[7:0];
    end
    r.red   = ch[0];
    r.green = ch[1];
    r.blue  = ch[2];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pack_pos(int x, int y);
    return {y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
  endfunction

  task automatic queue_pixel(int x, int y);
    bci_pkg::pixel_t p;
    p.pixel_x = x[PX_W-1:0];
    p.pixel_y = y[PX_W-1:0];
    pixel_backlog.push_back(p);
  endtask

  // quiet point: no pixel waiting or driven, no result owed, pipeline drained
  task automatic wait_idle();
    while (pixel_backlog.size() != 0 || start || expected_shades.size() != 0)
      @(posedge clk);
    repeat (bci_pkg::LATENCY + 4) @(posedge clk);
  endtask

  // holds valid high across back-to-back writes; caller drops it at the end
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_triangle(logic [POS_W-1:0] pa, logic [POS_W-1:0] pb,
                               logic [POS_W-1:0] pc, logic [COLOR_W-1:0] ca,
                               logic [COLOR_W-1:0] cb, logic [COLOR_W-1:0] cc,
                               bit stray);
    wait_idle();
    write_reg(bci_pkg::REG_A_POS, pa);
    write_reg(bci_pkg::REG_B_POS, pb);
    write_reg(bci_pkg::REG_C_POS, pc);
    write_reg(bci_pkg::REG_A_COLOR, ca);
    write_reg(bci_pkg::REG_B_COLOR, cb);
    write_reg(bci_pkg::REG_C_COLOR, cc);
    // writes to the holes in the register map must leave the triangle alone
    if (stray) begin
      write_reg(REG_UNUSED_LO, CFG_W'($urandom));
      write_reg(REG_UNUSED_HI, CFG_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // register shadow: follows every accepted write, reset values on rst
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tri_pos[0]   = '0;
      tri_pos[1]   = '0;
      tri_pos[2]   = '0;
      tri_color[0] = bci_pkg::A_COLOR_RST;
      tri_color[1] = bci_pkg::B_COLOR_RST;
      tri_color[2] = bci_pkg::C_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bci_pkg::REG_A_POS:   tri_pos[0]   = cfg_data[POS_W-1:0];
        bci_pkg::REG_B_POS:   tri_pos[1]   = cfg_data[POS_W-1:0];
        bci_pkg::REG_C_POS:   tri_pos[2]   = cfg_data[POS_W-1:0];
        bci_pkg::REG_A_COLOR: tri_color[0] = cfg_data[COLOR_W-1:0];
        bci_pkg::REG_B_COLOR: tri_color[1] = cfg_data[COLOR_W-1:0];
        bci_pkg::REG_C_COLOR: tri_color[2] = cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pixel driver
  // bursts of random length separated by random gaps; a quarter of the gaps
  // are empty so long unbroken runs at full rate also occur. the prediction
  // is made at the edge that takes the item, against the shadow registers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy)
        expected_shades.push_back(shade_pixel(pixel));
      if (start && busy) begin
        // item not taken yet, keep it on the port
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        start <= 1'b1;
        pixel <= pixel_backlog.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: in-order compare, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bci_pkg::result_t want;
    if (!rst && result_valid) begin
      if (expected_shades.size() == 0) begin
        $error("result with no pixel outstanding: %h", result);
        mismatches++;
      end else begin
        want = expected_shades.pop_front();
        check_field("red", want.red, result.red);
        check_field("green", want.green, result.green);
        check_field("blue", want.blue, result.blue);
        check_field("degenerate", want.degenerate, result.degenerate);
      end
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("barycentric_color_interpolator test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [POS_W-1:0]   pos [3];
    logic [COLOR_W-1:0] col [3];
    int kind, cx, cy, spread;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset registers put all three vertices on the origin: zero area
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    queue_pixel(1024, 512);

    // right triangle, counter-clockwise: vertices, interior, edge, outside
    load_triangle(pack_pos(0, 0), pack_pos(100, 0), pack_pos(0, 100),
                  24'hFF8000, 24'h00FF40, 24'h2020FF, 1'b1);
    queue_pixel(0, 0);
    queue_pixel(100, 0);
    queue_pixel(0, 100);
    queue_pixel(33, 33);
    queue_pixel(50, 50);
    queue_pixel(200, 200);
    queue_pixel(2047, 2047);
    queue_pixel(2047, 0);
    queue_pixel(0, 2047);

    // extreme coordinates with clockwise winding, saturated and black colors
    load_triangle(pack_pos(-2048, -2048), pack_pos(-2048, 2047),
                  pack_pos(2047, -2048), 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    queue_pixel(1000, 10);
    queue_pixel(5, 2000);

    // small clockwise triangle, pixels inside and well past the far edge
    load_triangle(pack_pos(10, 10), pack_pos(10, 300), pack_pos(300, 10),
                  24'h123456, 24'hA0B0C0, 24'h0F80F0, 1'b0);
    queue_pixel(10, 10);
    queue_pixel(100, 100);
    queue_pixel(400, 400);
    queue_pixel(0, 0);

    // collinear vertices: zero area without repeated points
    load_triangle(pack_pos(1, 1), pack_pos(2, 2), pack_pos(3, 3),
                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    queue_pixel(2, 2);
    queue_pixel(700, 1500);

    // random triangles: mostly placed in the pixel window with pixels around
    // them, some with raw random registers, some with a repeated vertex
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = $urandom_range(0, 9);
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 1500)
                                          : $urandom_range(1, 120);
      for (int v = 0; v < 3; v++) begin
        pos[v] = pack_pos(cx + $urandom_range(0, 2 * spread) - spread,
                          cy + $urandom_range(0, 2 * spread) - spread);
        col[v] = ($urandom_range(0, 4) == 0) ?
                 ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000) :
                 COLOR_W'($urandom);
      end
      if (kind == 0) begin
        for (int v = 0; v < 3; v++) pos[v] = POS_W'($urandom);
      end else if (kind == 1) begin
        pos[$urandom_range(1, 2)] = pos[0];
      end
      load_triangle(pos[0], pos[1], pos[2], col[0], col[1], col[2],
                    $urandom_range(0, 3) == 0);
      repeat (PIXELS_PER_PHASE) begin
        if (kind == 0 || $urandom_range(0, 2) == 0)
          queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
        else
          queue_pixel(cx + $urandom_range(0, 2 * spread + 100) - spread - 50,
                      cy + $urandom_range(0, 2 * spread + 100) - spread - 50);
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("barycentric_color_interpolator test passed");
    else
      $display("barycentric_color_interpolator test failed");
    $finish;
  end

endmodule
